>>> design/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// ante in one cycle implies cons in the next
`define HUF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// cond in one cycle implies sig unchanged in the next
`define HUF_ASSERT_HOLD(lbl, clk, rst_n, cond, sig) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
    else $error("assertion failed");

`endif

>>> design/huf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huf_pkg
// Types and constants of the Huffman tree decoder.
// ----------------------------------------------------------------------------
package huf_pkg;

  localparam int IDX_W         = 9;
  localparam int SYM_W         = 8;
  localparam int BITS_PER_BYTE = 8;
  localparam int BYTE_W        = 8;
  localparam int PAD_W         = 3;
  localparam int CFG_W         = 9;
  localparam int CFG_IDX_W     = 1;
  localparam int CNT_W         = $clog2(BITS_PER_BYTE + 1);
  localparam int BIT_IDX_W     = $clog2(BITS_PER_BYTE);

  localparam logic [IDX_W-1:0] ROOT_RESET = IDX_W'(510);

  // item kinds
  localparam logic KIND_NODE = 1'b0;
  localparam logic KIND_BYTE = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PADDING = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROOT    = 1'b1;

  typedef struct packed {
    logic [IDX_W-1:0] left;
    logic [IDX_W-1:0] right;
    logic             leaf;
    logic [SYM_W-1:0] sym;
  } node_t;

  typedef struct packed {
    logic              kind;
    logic [IDX_W-1:0]  node_index;
    logic [IDX_W-1:0]  left_index;
    logic [IDX_W-1:0]  right_index;
    logic              is_leaf;
    logic [SYM_W-1:0]  leaf_symbol;
    logic [BYTE_W-1:0] code_byte;
    logic              final_byte;
  } in_beat_t;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             run_last;
    logic             stream_done;
  } out_beat_t;

  // walker -> output stage
  typedef struct packed {
    logic             leaf;   // a leaf was reached
    logic             flush;  // end of byte
    logic             fin;    // byte is the final one
    logic [SYM_W-1:0] sym;
  } huf_emit_t;

endpackage

>>> design/huf_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huf_stream_if
// Valid/ready stream channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface huf_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> design/huf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huf_ram
// Generic RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module huf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // read data holds while no read is issued
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/huf_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huf_out_stage
// Holds the newest symbol of a byte until the next one (or the end of the
// byte) shows whether it is the last; feeds the output register.
// ----------------------------------------------------------------------------
module huf_out_stage import huf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  huf_emit_t emit_i,
  output logic      emit_ok_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_beat_t out_beat_o
);

  logic             hold_valid_q, hold_valid_d;
  logic [SYM_W-1:0] hold_sym_q;
  logic             hold_fin_q;
  logic             out_valid_q, out_valid_d;
  out_beat_t        out_q;
  logic             out_free;
  logic             need_out;
  logic             push;
  logic             take;

  assign out_free  = !out_valid_q || out_ready_i;
  assign need_out  = hold_valid_q && (emit_i.leaf || emit_i.flush);
  assign emit_ok_o = !need_out || out_free;
  assign push      = need_out && out_free;
  assign take      = emit_i.leaf && emit_ok_o;

  always_comb begin
    hold_valid_d = hold_valid_q;
    if (take) begin
      hold_valid_d = 1'b1;
    end else if (emit_i.flush && emit_ok_o) begin
      hold_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (push) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      hold_valid_q <= hold_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      hold_sym_q <= emit_i.sym;
      hold_fin_q <= emit_i.fin;
    end
    if (push) begin
      out_q.symbol      <= hold_sym_q;
      out_q.run_last    <= emit_i.flush;
      out_q.stream_done <= hold_fin_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

endmodule

>>> design/huffman_tree_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_tree_decoder
// Huffman decoder walking a node table held in a synchronous RAM.
// ----------------------------------------------------------------------------
//  channel | dir | beat                                   | handshake
//  --------+-----+----------------------------------------+--------------
//  in_i    | in  | node write (kind 0) or code byte (1)   | valid/ready
//  out_o   | out | symbol, run_last, stream_done          | valid/ready
//  cfg     | in  | padding_bits (0), root_node (1)        | cfg_we_i only
//
//  A code byte uses N bits (8, or 8 - padding on a final byte): one read of
//  the node the walk stands on, then one node-table read per bit, plus one
//  root re-read after each leaf that leaves bits in the byte.
//  The RAM read port sets the rate: each step's address is the child field
//  of the previous read.
//  Reset idles control, sets walk position and root to 510, padding to 0;
//  table content stays undefined until written. A full output register stalls
//  the walk only when a symbol must move to it; a new item is taken while it waits.
// ----------------------------------------------------------------------------
module huffman_tree_decoder import huf_pkg::*; #(
  parameter int TREE_NODES = 512
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  huf_stream_if.sink           in_i,
  huf_stream_if.source         out_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i
);

  localparam int AW = $clog2(TREE_NODES);

  // walker states
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,  // waiting for an item
    S_LOAD  = 4'b0010,  // read data is the node the walk stands on
    S_STEP  = 4'b0100,  // read data is the child just entered
    S_FLUSH = 4'b1000   // byte done, release the held symbol
  } state_e;

  state_e state_q, state_d;

  // registers
  logic [PAD_W-1:0]  pad_q;
  logic [IDX_W-1:0]  root_q;

  // walk
  logic [IDX_W-1:0]  pos_q, pos_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [CNT_W-1:0]  nbits_q, nbits_d;
  logic [BYTE_W-1:0] byte_q;
  logic              fin_q;
  logic              rd_ok_q, rd_ok_d;

  // RAM
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  node_t             ram_wdata;
  logic              ram_re;
  logic [IDX_W-1:0]  rd_idx;
  logic [$bits(node_t)-1:0] ram_rdata;

  in_beat_t          beat;
  node_t             entry;
  logic              in_accept;
  logic              code_bit;
  logic [IDX_W-1:0]  child;
  logic              bits_left;
  huf_emit_t         emit;
  logic              emit_ok;

  function automatic logic idx_ok(logic [IDX_W-1:0] idx);
    return 32'(idx) < 32'(TREE_NODES);
  endfunction

  assign beat      = in_i.data;
  assign in_accept = in_i.valid && in_i.ready;

  // an index past the table reads as an all-zero node
  assign entry     = rd_ok_q ? node_t'(ram_rdata) : '0;
  assign code_bit  = byte_q[cnt_q[BIT_IDX_W-1:0]];
  assign child     = code_bit ? entry.right : entry.left;
  assign bits_left = cnt_q != nbits_q;

  assign ram_waddr = AW'(beat.node_index);
  assign ram_wdata = '{left:  beat.left_index, right: beat.right_index,
                       leaf:  beat.is_leaf,    sym:   beat.leaf_symbol};

  always_comb begin
    state_d    = state_q;
    pos_d      = pos_q;
    cnt_d      = cnt_q;
    nbits_d    = nbits_q;
    rd_ok_d    = rd_ok_q;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    rd_idx     = pos_q;
    in_i.ready = 1'b0;
    emit       = '{leaf: 1'b0, flush: 1'b0, fin: fin_q, sym: entry.sym};

    unique case (state_q)
      S_IDLE: begin
        in_i.ready = 1'b1;
        if (in_accept) begin
          if (beat.kind == KIND_NODE) begin
            ram_we = idx_ok(beat.node_index);
          end else begin
            // fetch the node the walk stands on
            ram_re  = 1'b1;
            rd_idx  = pos_q;
            cnt_d   = '0;
            nbits_d = beat.final_byte
                    ? CNT_W'(BITS_PER_BYTE) - CNT_W'(pad_q)
                    : CNT_W'(BITS_PER_BYTE);
            state_d = S_LOAD;
          end
        end
      end
      S_LOAD: begin
        // at least one bit is always left here
        ram_re  = 1'b1;
        rd_idx  = child;
        pos_d   = child;
        cnt_d   = cnt_q + 1'b1;
        state_d = S_STEP;
      end
      S_STEP: begin
        if (entry.leaf) begin
          emit.leaf = 1'b1;
          if (emit_ok) begin
            pos_d = root_q;
            if (bits_left) begin
              ram_re  = 1'b1;
              rd_idx  = root_q;
              state_d = S_LOAD;
            end else begin
              state_d = S_FLUSH;
            end
          end
        end else if (bits_left) begin
          ram_re = 1'b1;
          rd_idx = child;
          pos_d  = child;
          cnt_d  = cnt_q + 1'b1;
        end else begin
          state_d = S_FLUSH;
        end
      end
      S_FLUSH: begin
        emit.flush = 1'b1;
        if (emit_ok) begin
          // a partial code in the final byte is dropped
          if (fin_q) begin
            pos_d = root_q;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (ram_re) begin
      rd_ok_d = idx_ok(rd_idx);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pos_q   <= ROOT_RESET;
      root_q  <= ROOT_RESET;
      pad_q   <= '0;
      cnt_q   <= '0;
      rd_ok_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      cnt_q   <= cnt_d;
      rd_ok_q <= rd_ok_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_PADDING: pad_q  <= cfg_wdata_i[PAD_W-1:0];
          CFG_ROOT:    root_q <= cfg_wdata_i[IDX_W-1:0];
          default:     ;
        endcase
      end
    end
  end

  // byte payload
  always_ff @(posedge clk_i) begin
    if (in_accept && beat.kind == KIND_BYTE) begin
      byte_q  <= beat.code_byte;
      fin_q   <= beat.final_byte;
      nbits_q <= nbits_d;
    end
  end

  huf_ram #(
    .WIDTH ($bits(node_t)),
    .DEPTH (TREE_NODES)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (AW'(rd_idx)),
    .rdata_o (ram_rdata)
  );

  huf_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .emit_i      (emit),
    .emit_ok_o   (emit_ok),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_beat_o  (out_o.data)
  );

endmodule

>>> design/huf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huf_checker
// Port-level checks of the Huffman tree decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module huf_checker import huf_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_i,
  input logic      in_kind_i,
  input logic      out_valid_i,
  input logic      out_ready_i,
  input out_beat_t out_beat_i
);

  logic in_acc;
  logic out_stall;

  assign in_acc    = in_valid_i && in_ready_i;
  assign out_stall = out_valid_i && !out_ready_i;

  `HUF_ASSERT_NEXT(a_out_valid_held, clk_i, rst_ni, out_stall, out_valid_i)
  `HUF_ASSERT_HOLD(a_out_beat_held, clk_i, rst_ni, out_stall, out_beat_i)
  // node writes never produce a result
  `HUF_ASSERT_NEXT(a_node_no_beat, clk_i, rst_ni, in_acc && in_kind_i == KIND_NODE && !out_stall, !out_valid_i)
  // a code byte occupies the walker
  `HUF_ASSERT_NEXT(a_byte_busy, clk_i, rst_ni, in_acc && in_kind_i == KIND_BYTE, !in_ready_i)

endmodule

bind huffman_tree_decoder huf_checker u_huf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_kind_i   (in_i.data.kind),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_beat_i  (out_o.data)
);
